// ===== rtl/core/ktr_pkg.sv =====
// shared constants, types and the modifier key map for the typematic repeat unit
package ktr_pkg;

  localparam int ROWS      = 5;
  localparam int HALF_COLS = 8;
  localparam int NROWS     = 2 * ROWS;
  localparam int ADDR_W    = $clog2(NROWS);
  localparam int ROW_W     = 3;
  localparam int COL_W     = 3;
  localparam int CNT_W     = 8;
  localparam int DATA_W    = 8;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] INITIAL_DELAY_RST = CNT_W'(60);
  localparam logic [CNT_W-1:0] REPEAT_DELAY_RST  = CNT_W'(6);
  localparam logic [CNT_W-1:0] CNT_MAX           = '1;

  typedef enum logic [1:0] {
    ACT_TAP     = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_RELEASE = 2'd2
  } act_t;

  typedef struct packed {
    logic             long_hold;
    logic [CNT_W-1:0] count;
  } lane_state_t;

  typedef lane_state_t [HALF_COLS-1:0] row_state_t;

  typedef struct packed {
    logic emit;
    act_t act;
  } lane_evt_t;

  // events of one row, mask and actions indexed by visit position
  typedef struct packed {
    logic                 side;
    logic [ROW_W-1:0]     row;
    logic [HALF_COLS-1:0] mask;
    act_t [HALF_COLS-1:0] acts;
  } row_evt_t;

  function automatic logic is_modifier(input logic side, input logic [ROW_W-1:0] r,
                                       input logic [COL_W-1:0] c);
    logic hit;
    if (!side) begin
      hit = (r == ROW_W'(3) && c == COL_W'(0)) || (r == ROW_W'(4) && c == COL_W'(0)) ||
            (r == ROW_W'(4) && c == COL_W'(2)) || (r == ROW_W'(4) && c == COL_W'(3));
    end else begin
      hit = (r == ROW_W'(3) && c == COL_W'(5)) || (r == ROW_W'(4) && c == COL_W'(2)) ||
            (r == ROW_W'(4) && c == COL_W'(4));
    end
    return hit;
  endfunction

endpackage

// ===== rtl/core/ktr_in_if.sv =====
// scanned row channel
interface ktr_in_if;
  import ktr_pkg::*;
  logic             valid;
  logic             ready;
  logic             half;
  logic [ROW_W-1:0] row_index;
  logic [HALF_COLS-1:0] column_bits;

  modport source(output valid, half, row_index, column_bits, input ready);
  modport sink(input valid, half, row_index, column_bits, output ready);
endinterface

// ===== rtl/core/ktr_out_if.sv =====
// key event channel
interface ktr_out_if;
  import ktr_pkg::*;
  logic             valid;
  logic             ready;
  logic             side;
  logic [ROW_W-1:0] key_row;
  logic [COL_W-1:0] key_col;
  logic [1:0]       action;
  logic             last;

  modport source(output valid, side, key_row, key_col, action, last, input ready);
  modport sink(input valid, side, key_row, key_col, action, last, output ready);
endinterface

// ===== rtl/core/ktr_cfg_if.sv =====
// configuration write channel
interface ktr_cfg_if;
  import ktr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/ktr_lane.sv =====
// per-key hold counter update and event decision
module ktr_lane (
  input  logic                      down,
  input  logic                      is_mod,
  input  ktr_pkg::lane_state_t      cur,
  input  logic [ktr_pkg::CNT_W-1:0] initial_delay,
  input  logic [ktr_pkg::CNT_W-1:0] repeat_delay,
  output ktr_pkg::lane_state_t      nxt,
  output ktr_pkg::lane_evt_t        evt
);
  import ktr_pkg::*;

  logic [CNT_W-1:0] cnt;

  always_comb begin
    nxt      = cur;
    evt.emit = 1'b0;
    evt.act  = ACT_TAP;
    cnt      = cur.count;
    if (is_mod) begin
      evt.emit = 1'b1;
      evt.act  = down ? ACT_PRESS : ACT_RELEASE;
    end else if (down) begin
      if (cur.count == '0) begin
        evt.emit = 1'b1;
      end else if (cur.long_hold && cur.count > repeat_delay) begin
        evt.emit = 1'b1;
        cnt      = CNT_W'(1);
      end else if (cur.count > initial_delay) begin
        nxt.long_hold = 1'b1;
      end
      nxt.count = (cnt != CNT_MAX) ? cnt + CNT_W'(1) : cnt;
    end else begin
      nxt.count     = '0;
      nxt.long_hold = 1'b0;
    end
  end

endmodule

// ===== rtl/core/ktr_merge.sv =====
// event buffer that hands out one row's events in visit order
module ktr_merge (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ktr_pkg::row_evt_t load_evt,
  output logic              free,
  ktr_out_if.source         events
);
  import ktr_pkg::*;

  logic                 busy;
  row_evt_t             cur;
  logic [COL_W-1:0]     pos;
  logic                 found;
  logic [HALF_COLS-1:0] rest;
  logic                 is_last;
  logic                 fire;

  // lowest pending visit position
  always_comb begin
    pos   = '0;
    found = 1'b0;
    for (int p = 0; p < HALF_COLS; p++) begin
      if (cur.mask[p] && !found) begin
        pos   = COL_W'(p);
        found = 1'b1;
      end
    end
  end

  assign rest    = cur.mask & ~(HALF_COLS'(1) << pos);
  assign is_last = (rest == '0);
  assign fire    = events.valid && events.ready;
  assign free    = !busy || (events.ready && is_last);

  assign events.valid   = busy;
  assign events.side    = cur.side;
  assign events.key_row = cur.row;
  assign events.key_col = cur.side ? pos : COL_W'(HALF_COLS - 1) - pos;
  assign events.action  = cur.acts[pos];
  assign events.last    = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (fire && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= load_evt;
    end else if (fire) begin
      cur.mask <= rest;
    end
  end

endmodule

// ===== rtl/core/key_matrix_typematic_repeat_unit.sv =====
// top level of the key matrix typematic repeat unit
// a taken row item is registered into the lane stage, then its events are loaded into the
//   event buffer once it is free; events leave one per cycle while the event channel is ready
// throughput: one row item per cycle while rows carry no events; a row with events waits
//   in the lane stage until the single event buffer in the merge stage is free
// reset: synchronous, clears the row-state valid bits, pipeline and buffer, delays to 60 and 6
module key_matrix_typematic_repeat_unit (
  input  logic      clk,
  input  logic      rst,
  ktr_in_if.sink    items,
  ktr_out_if.source events,
  ktr_cfg_if.sink   cfg
);
  import ktr_pkg::*;

  // configuration registers
  logic [CNT_W-1:0] initial_delay;
  logic [CNT_W-1:0] repeat_delay;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay <= INITIAL_DELAY_RST;
      repeat_delay  <= REPEAT_DELAY_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_INITIAL_DELAY: initial_delay <= cfg.data;
        REG_REPEAT_DELAY:  repeat_delay  <= cfg.data;
        default: ;
      endcase
    end
  end

  // row state memory: one word holds the eight keys of one row of one half
  row_state_t       mem [NROWS];
  logic [NROWS-1:0] row_valid;

  // input side
  logic              in_fire;
  logic              in_range;
  logic              load;
  logic [ADDR_W-1:0] addr;

  // lane stage registers
  logic                 s1_valid;
  logic                 s1_side;
  logic [ROW_W-1:0]     s1_row;
  logic [HALF_COLS-1:0] s1_bits;
  logic [ADDR_W-1:0]    s1_addr;
  row_state_t           mem_q;
  logic                 rv_q;
  logic                 fwd_q;
  row_state_t           fwd_data;
  logic                 s1_adv;

  // lane signals
  row_state_t           cur_state;
  row_state_t           new_state;
  lane_evt_t [HALF_COLS-1:0] lane_evt;
  logic [HALF_COLS-1:0] lane_down;
  logic [HALF_COLS-1:0] lane_mod;
  row_evt_t             row_evt;
  logic                 merge_free;
  logic                 merge_load;

  assign in_range    = (int'(items.row_index) < ROWS);
  assign in_fire     = items.valid && items.ready;
  assign load        = in_fire && in_range;
  assign addr        = ADDR_W'(items.row_index) + (items.half ? ADDR_W'(ROWS) : '0);
  // take a new row whenever the lane stage is empty or moves on this cycle
  assign items.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= load;
    end
  end

  // read the row word, and catch a write-back to the same row in the same cycle
  always_ff @(posedge clk) begin
    if (load) begin
      s1_side  <= items.half;
      s1_row   <= items.row_index;
      s1_bits  <= items.column_bits;
      s1_addr  <= addr;
      mem_q    <= mem[addr];
      rv_q     <= row_valid[addr];
      fwd_q    <= s1_valid && (s1_addr == addr);
      fwd_data <= new_state;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mem[s1_addr] <= new_state;
    end
  end

  // a row never written reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (s1_adv) begin
      row_valid[s1_addr] <= 1'b1;
    end
  end

  assign cur_state = fwd_q ? fwd_data : (rv_q ? mem_q : '0);

  // one lane per remapped column; right half bits arrive reversed
  for (genvar c = 0; c < HALF_COLS; c++) begin : g_lane
    assign lane_down[c] = s1_side ? s1_bits[HALF_COLS-1-c] : s1_bits[c];
    assign lane_mod[c]  = is_modifier(s1_side, s1_row, COL_W'(c));

    ktr_lane u_lane (
      .down          (lane_down[c]),
      .is_mod        (lane_mod[c]),
      .cur           (cur_state[c]),
      .initial_delay (initial_delay),
      .repeat_delay  (repeat_delay),
      .nxt           (new_state[c]),
      .evt           (lane_evt[c])
    );
  end

  // reorder lane events into visit order: left goes high column first, right low first
  always_comb begin
    row_evt.side = s1_side;
    row_evt.row  = s1_row;
    for (int p = 0; p < HALF_COLS; p++) begin
      if (s1_side) begin
        row_evt.mask[p] = lane_evt[p].emit;
        row_evt.acts[p] = lane_evt[p].act;
      end else begin
        row_evt.mask[p] = lane_evt[HALF_COLS-1-p].emit;
        row_evt.acts[p] = lane_evt[HALF_COLS-1-p].act;
      end
    end
  end

  // rows without events retire at once; others wait for the event buffer
  assign s1_adv     = s1_valid && ((row_evt.mask == '0) || merge_free);
  assign merge_load = s1_adv && (row_evt.mask != '0);

  ktr_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (merge_load),
    .load_evt (row_evt),
    .free     (merge_free),
    .events   (events)
  );

  // a stalled lane stage always has events waiting for the buffer
  a_stall_has_events: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> (row_evt.mask != '0))
    else $error("lane stage stalled with no events");

  // a retired row is marked written on the next cycle
  a_row_marked: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> row_valid[$past(s1_addr)])
    else $error("row valid bit not set after write-back");

  // back-to-back rows on the same word take the forwarded state
  a_forward: assert property (@(posedge clk) disable iff (rst)
    (load && s1_valid && (s1_addr == addr)) |=> fwd_q)
    else $error("same-row forwarding missed");

endmodule

// ===== test/ktr_event_checker.sv =====
// event predictor and in-order comparator for the typematic repeat unit
module ktr_event_checker
  import ktr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ktr_in_if    items,
  ktr_out_if   events,
  ktr_cfg_if   cfg,
  output int   mismatch_count,
  output int   events_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             side;
    logic [ROW_W-1:0] key_row;
    logic [COL_W-1:0] key_col;
    act_t             action;
    logic             last;
  } key_event_t;

  logic [CNT_W-1:0] hold_cnt [2][ROWS][HALF_COLS];
  logic             repeating [2][ROWS][HALF_COLS];
  logic [CNT_W-1:0] first_delay;
  logic [CNT_W-1:0] repeat_gap;
  key_event_t       owed_events [$];
  int               errs;

  initial begin
    mismatch_count = 0;
    events_owed    = 0;
    errs           = 0;
  end

  // shift and modifier keys, column already remapped
  function automatic logic modifier_key(input logic s, input int r, input int c);
    if (s) return (r == 3 && c == 5) || (r == 4 && (c == 2 || c == 4));
    return (r == 3 && c == 0) || (r == 4 && (c == 0 || c == 2 || c == 3));
  endfunction

  task automatic predict_row_events(input logic s, input logic [ROW_W-1:0] r,
                                    input logic [HALF_COLS-1:0] bits);
    int               b;
    int               col;
    int               queued;
    logic [CNT_W-1:0] cnt;
    logic             fire;
    act_t             act;
    key_event_t       ev;
    if (r >= ROWS) return;
    queued = owed_events.size();
    for (b = HALF_COLS - 1; b >= 0; b--) begin
      col  = s ? HALF_COLS - 1 - b : b;
      fire = 1'b0;
      act  = ACT_TAP;
      if (modifier_key(s, r, col)) begin
        fire = 1'b1;
        act  = bits[b] ? ACT_PRESS : ACT_RELEASE;
      end else if (bits[b]) begin
        cnt = hold_cnt[s][r][col];
        if (cnt == '0) begin
          fire = 1'b1;
        end else if (repeating[s][r][col] && cnt > repeat_gap) begin
          fire = 1'b1;
          cnt  = CNT_W'(1);
        end else if (cnt > first_delay) begin
          repeating[s][r][col] = 1'b1;
        end
        if (cnt != CNT_MAX) cnt = cnt + 1'b1;
        hold_cnt[s][r][col] = cnt;
      end else begin
        hold_cnt[s][r][col]  = '0;
        repeating[s][r][col] = 1'b0;
      end
      if (fire) begin
        ev.side    = s;
        ev.key_row = r;
        ev.key_col = COL_W'(col);
        ev.action  = act;
        ev.last    = 1'b0;
        owed_events.push_back(ev);
      end
    end
    if (owed_events.size() > queued) begin
      ev      = owed_events.pop_back();
      ev.last = 1'b1;
      owed_events.push_back(ev);
    end
  endtask

  task automatic compare_field(input string field, input logic [3:0] want,
                               input logic [3:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    key_event_t want;
    if (rst) begin
      foreach (hold_cnt[s, r, c]) begin
        hold_cnt[s][r][c]  = '0;
        repeating[s][r][c] = 1'b0;
      end
      first_delay = INITIAL_DELAY_RST;
      repeat_gap  = REPEAT_DELAY_RST;
      owed_events.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_INITIAL_DELAY: first_delay = cfg.data;
          REG_REPEAT_DELAY:  repeat_gap  = cfg.data;
          default: ;
        endcase
      end
      if (items.valid && items.ready)
        predict_row_events(items.half, items.row_index, items.column_bits);
      if (events.valid && events.ready) begin
        if (owed_events.size() == 0) begin
          $display("%0t ns: key event with none expected, got side %0d row %0d col %0d action %0d",
                   $time, events.side, events.key_row, events.key_col, events.action);
          errs++;
        end else begin
          want = owed_events.pop_front();
          compare_field("side", 4'(want.side), 4'(events.side));
          compare_field("key_row", 4'(want.key_row), 4'(events.key_row));
          compare_field("key_col", 4'(want.key_col), 4'(events.key_col));
          compare_field("action", 4'(want.action), 4'(events.action));
          compare_field("last", 4'(want.last), 4'(events.last));
        end
      end
    end
    events_owed    <= owed_events.size();
    mismatch_count <= errs;
  end

endmodule

// ===== test/tb_key_matrix_typematic_repeat_unit.sv =====
// stimulus, idling and verdict for the typematic repeat unit regression
module tb_key_matrix_typematic_repeat_unit;
  import ktr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // well above the slowest legal run: ~400 rows, each up to 8 events that can each
  // sit out a stall of the event sink, plus sender gaps, drains and pipeline cycles
  localparam int CYCLE_LIMIT = 600000;
  // a row item is registered into the lane stage before it retires, so this covers rows with none
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS = 16;
  localparam int SATURATE_SCANS = 258;

  logic clk;
  logic rst;
  int   cycle_count;
  int   mismatch_count;
  int   events_owed;
  bit   calm;   // set for the last stretch: no gaps on either side
  int   cur_init;
  int   cur_rep;

  ktr_in_if  row_ch ();
  ktr_out_if evt_ch ();
  ktr_cfg_if cfg_ch ();

  key_matrix_typematic_repeat_unit dut (
    .clk    (clk),
    .rst    (rst),
    .items  (row_ch),
    .events (evt_ch),
    .cfg    (cfg_ch)
  );

  ktr_event_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .items          (row_ch),
    .events         (evt_ch),
    .cfg            (cfg_ch),
    .mismatch_count (mismatch_count),
    .events_owed    (events_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run guard
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("key_matrix_typematic_repeat_unit regression: fail");
      $finish;
    end
  end

  // event sink: ready high in stretches, dropped in random stall bursts
  initial begin
    evt_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        evt_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      evt_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // one row scan; valid stays up across back-to-back items unless a gap is chosen
  task automatic send_row(input logic h, input logic [ROW_W-1:0] r,
                          input logic [HALF_COLS-1:0] bits);
    if (!calm && $urandom_range(0, 5) == 0) begin
      row_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    row_ch.valid       <= 1'b1;
    row_ch.half        <= h;
    row_ch.row_index   <= r;
    row_ch.column_bits <= bits;
    do @(posedge clk); while (!row_ch.ready);
  endtask

  // stop sending and wait for every owed event, then let rows without events retire
  task automatic drain_all();
    row_ch.valid <= 1'b0;
    do @(posedge clk); while (events_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both delay registers in one burst; optionally hit the unmapped indexes first
  task automatic program_delays(input int init_d, input int rep_d, input bit stray);
    int i;
    cfg_ch.valid <= 1'b1;
    if (stray) begin
      for (i = int'(REG_REPEAT_DELAY) + 1; i < 2 ** CFG_IDX_W; i++) begin
        cfg_ch.index <= CFG_IDX_W'(i);
        cfg_ch.data  <= DATA_W'($urandom_range(0, 255));
        do @(posedge clk); while (!cfg_ch.ready);
      end
    end
    cfg_ch.index <= REG_INITIAL_DELAY;
    cfg_ch.data  <= DATA_W'(init_d);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_REPEAT_DELAY;
    cfg_ch.data  <= DATA_W'(rep_d);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_init = init_d;
    cur_rep  = rep_d;
  endtask

  // keys held on one row for a random number of scans, capped at 70, with glitches and
  // stray scans of other rows mixed in
  task automatic hold_episodes(input int n_items);
    int                   sent;
    int                   span;
    int                   k;
    logic                 h;
    logic [ROW_W-1:0]     r;
    logic [ROW_W-1:0]     noise_r;
    logic [HALF_COLS-1:0] held;
    logic [HALF_COLS-1:0] bits;
    sent = 0;
    while (sent < n_items) begin
      h    = 1'($urandom_range(0, 1));
      r    = ROW_W'($urandom_range(0, ROWS - 1));
      held = HALF_COLS'($urandom_range(0, 255));
      span = cur_init + 3 * cur_rep + 6;
      if (span > 70) span = 70;
      span = $urandom_range(1, span);
      for (k = 0; k < span && sent < n_items; k++) begin
        bits = held;
        // key bounce: one bit flips for a single scan
        if ($urandom_range(0, 7) == 0) bits = bits ^ HALF_COLS'(1 << $urandom_range(0, 7));
        // a key goes down or up for good mid-episode
        if ($urandom_range(0, 15) == 0) held = held ^ HALF_COLS'(1 << $urandom_range(0, 7));
        if ($urandom_range(0, 11) == 0) begin
          noise_r = ROW_W'($urandom_range(0, 7));
          send_row(1'($urandom_range(0, 1)), noise_r, HALF_COLS'($urandom_range(0, 255)));
          if (noise_r < ROWS) sent++;
        end
        send_row(h, r, bits);
        sent++;
      end
    end
  endtask

  initial begin
    int phase_init [5];
    int phase_rep  [5];
    int p;
    int n;

    phase_init         = '{0, 20, 0, 3, 250};
    phase_rep          = '{0, 0, 20, 2, 250};
    calm               = 1'b0;
    cur_init           = int'(INITIAL_DELAY_RST);
    cur_rep            = int'(REPEAT_DELAY_RST);
    rst                = 1'b1;
    row_ch.valid       <= 1'b0;
    row_ch.half        <= 1'b0;
    row_ch.row_index   <= '0;
    row_ch.column_bits <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_INITIAL_DELAY;
    cfg_ch.data        <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unmapped register indexes must leave the reset delays alone
    program_delays(int'(INITIAL_DELAY_RST), int'(REPEAT_DELAY_RST), 1'b1);

    // directed: full and empty rows, both halves, every modifier in both states
    send_row(1'b0, 3'd0, 8'hFF);   // eight first-press taps
    send_row(1'b0, 3'd0, 8'hFF);   // held, still inside the initial delay
    send_row(1'b0, 3'd0, 8'h00);   // all released, nothing out
    send_row(1'b1, 3'd0, 8'h01);   // right half bit 0 lands on column 7
    send_row(1'b1, 3'd0, 8'h80);   // right half bit 7 lands on column 0
    send_row(1'b0, 3'd3, 8'h01);   // left shift press
    send_row(1'b0, 3'd3, 8'h00);   // left shift release
    send_row(1'b0, 3'd4, 8'h0D);   // three left modifiers down
    send_row(1'b0, 3'd4, 8'hF2);   // taps mixed with modifier releases
    send_row(1'b0, 3'd4, 8'h00);
    send_row(1'b1, 3'd3, 8'h04);   // right modifier at column 5
    send_row(1'b1, 3'd3, 8'hFB);
    send_row(1'b1, 3'd4, 8'h28);   // right modifiers at columns 2 and 4
    send_row(1'b1, 3'd4, 8'hFF);
    send_row(1'b1, 3'd4, 8'h00);
    send_row(1'b0, 3'd5, 8'hFF);   // rows past the matrix are dropped
    send_row(1'b1, 3'd6, 8'hFF);
    send_row(1'b0, 3'd7, 8'hFF);
    send_row(1'b1, 3'd7, 8'h00);
    send_row(1'b0, 3'd1, 8'hAA);
    send_row(1'b0, 3'd1, 8'h55);
    send_row(1'b1, 3'd2, 8'hFF);
    send_row(1'b1, 3'd2, 8'h7E);
    send_row(1'b0, 3'd2, 8'h00);
    drain_all();

    // random holds under a range of delay settings, zero and 250 included
    for (p = 0; p < 5; p++) begin
      program_delays(phase_init[p], phase_rep[p], 1'b0);
      hold_episodes(PHASE_ITEMS);
      drain_all();
    end

    // delays above the nominal range; the count must pin at its maximum
    // instead of wrapping back to a fresh tap
    program_delays(255, 255, 1'b0);
    for (n = 0; n < SATURATE_SCANS; n++)
      send_row(1'b0, 3'd0, HALF_COLS'($urandom_range(0, 255)) | 8'h80);
    drain_all();

    // closing stretch at full rate on both sides
    program_delays(7, 1, 1'b0);
    calm = 1'b1;
    hold_episodes(PHASE_ITEMS);
    drain_all();

    if (mismatch_count == 0 && events_owed == 0) begin
      $display("key_matrix_typematic_repeat_unit regression: pass");
    end else begin
      $display("key_matrix_typematic_repeat_unit regression: fail");
    end
    $finish;
  end

endmodule
